// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/fbce_pkg.sv =====
// ----------------------------------------------------------------------------
// fbce_pkg
// Types, constants and table builder for the focal BCE loss accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbce_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_POS_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCUS_GAMMA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ALPHA = 2'd2;

    localparam logic [15:0] POS_WEIGHT_RST    = 16'd256;
    localparam logic [15:0] FOCUS_GAMMA_RST   = 16'd8192;
    localparam logic [16:0] BALANCE_ALPHA_RST = 17'd16384;

    localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
    localparam logic [30:0]        EPS_Q30   = 31'd1074;
    localparam logic [30:0]        LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic signed [23:0] CLAMP_Q16 = 24'sd3276800;
    localparam logic [16:0]        ONE_Q16   = 17'd65536;
    localparam logic [16:0]        HALF_Q16  = 17'd32768;
    localparam logic [20:0]        COUNT_CAP = 21'h1F_FFFF;

    localparam int DIV_DVD_W = 64;
    localparam int DIV_DVS_W = 32;

    typedef enum logic [5:0] {
        ST_IDLE, ST_Y_MUL, ST_Y_GET,
        ST_EX_INIT, ST_EX_LOOP, ST_EX_ACC, ST_EX_SHIFT,
        ST_SIG_DIV, ST_SIG_WAIT,
        ST_LN_SETUP, ST_LG_NORM, ST_LG_SQ, ST_LG_SQA, ST_LN_MUL, ST_LN_GET,
        ST_BCE_M1, ST_BCE_M2, ST_BCE_GET, ST_AT_M1, ST_AT_M2, ST_AT_GET,
        ST_PW_SEL, ST_PW_MUL, ST_PW_GET,
        ST_AB_MUL, ST_AB_GET, ST_LOSS_MUL, ST_LOSS_GET, ST_PW8_MUL, ST_PW8_GET,
        ST_ACCUM, ST_MEAN_DIV, ST_MEAN_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } t_div_rsp;

    // floor square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b_;
        rem = v;
        res = '0;
        b_  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b_) begin
                rem = rem - (res + b_);
                res = (res >> 1) + b_;
            end else begin
                res = res >> 1;
            end
            b_ = b_ >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-(k+1)) in Q0.30
    function automatic logic [29:0] pow_tab_entry(input int k);
        logic [63:0] x;
        x = isqrt64(64'd1 << 59);
        for (int i = 1; i <= k; i++) begin
            x = isqrt64(x << 30);
        end
        return x[29:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/focal_bce_loss_accumulator.sv =====
// ----------------------------------------------------------------------------
// focal_bce_loss_accumulator
// Focal binary cross-entropy per word, running sum, batch mean on last.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  input   | i_in_valid/o_in_ready, logit label last   | in
//  output  | o_out_valid/i_out_ready, mean count sat   | out
//  config  | i_cfg_wr_en, i_cfg_index, i_cfg_wdata     | in
//
//  Each word runs on the single 32x32 multiplier shared by sigmoid, two logs,
//  pow and loss products, and on the one-bit-per-cycle divider; a last word
//  also runs the divider for the mean.
//  Reset is synchronous and clears sum, count, flag and registers to defaults.
//  A waiting result holds in the output register; only a second last word
//  stalls on it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module focal_bce_loss_accumulator #(
    parameter int unsigned MAX_BATCH = 1048576
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic signed [23:0]              i_logit,
    input  wire logic [16:0]                     i_label,
    input  wire logic                            i_last,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [31:0]                          o_mean_loss,
    output logic [20:0]                          o_batch_count,
    output logic                                 o_saturated,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [fbce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fbce_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fbce_pkg::*;

    localparam int unsigned LIMIT   = (MAX_BATCH > 2097151) ? 2097151 : MAX_BATCH;
    localparam logic [20:0] LIMIT_W = 21'(LIMIT);

    localparam logic [29:0] POW_TAB [16] = '{
        pow_tab_entry(0),  pow_tab_entry(1),  pow_tab_entry(2),  pow_tab_entry(3),
        pow_tab_entry(4),  pow_tab_entry(5),  pow_tab_entry(6),  pow_tab_entry(7),
        pow_tab_entry(8),  pow_tab_entry(9),  pow_tab_entry(10), pow_tab_entry(11),
        pow_tab_entry(12), pow_tab_entry(13), pow_tab_entry(14), pow_tab_entry(15)
    };

    t_state r_state, n_state, r_ret;

    // config
    logic [15:0] r_pos_w;
    logic [15:0] r_gamma;
    logic [16:0] r_balpha;

    // batch state
    logic [47:0] r_sum;
    logic [20:0] r_count;
    logic        r_ovf;

    // output register
    logic        r_ov;
    logic [31:0] r_mean;
    logic [20:0] r_bcnt;
    logic        r_sat;

    // word working set
    logic [21:0] r_mag;
    logic        r_neg_l;
    logic [16:0] r_t;
    logic [16:0] r_alpha;
    logic        r_last;
    logic [24:0] r_y;
    logic [30:0] r_r;
    logic [3:0]  r_k;
    logic [30:0] r_m;
    logic [4:0]  r_sh;
    logic [15:0] r_frac;
    logic        r_sel;
    logic [30:0] r_p;
    logic [30:0] r_q;
    logic [21:0] r_aln;
    logic [21:0] r_bln;
    logic [37:0] r_acc;
    logic [21:0] r_bce;
    logic [16:0] r_at;
    logic [21:0] r_ab;
    logic [29:0] r_loss;
    logic [63:0] r_prod;

    logic [31:0] mul_a, mul_b;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    fbce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------- helpers
    logic signed [23:0] l_cl;
    logic [23:0]        l_abs;
    logic [15:0]        f_bits;
    logic               f_bit;
    logic [4:0]         n5;
    logic [31:0]        ex_sh;
    logic signed [22:0] lg_neg;
    logic               lg_pos;
    logic [31:0]        m2;
    logic [30:0]        sig_small;
    logic [31:0]        sig_d;
    logic [48:0]        sum_nx;
    logic [48:0]        mean_dvd;
    logic [31:0]        mean_q;
    logic               out_free;

    always_comb begin
        if (i_logit > CLAMP_Q16) begin
            l_cl = CLAMP_Q16;
        end else if (i_logit < -CLAMP_Q16) begin
            l_cl = -CLAMP_Q16;
        end else begin
            l_cl = i_logit;
        end
        l_abs  = l_cl[23] ? 24'(-l_cl) : 24'(l_cl);
        f_bits = r_y[15:0];
        f_bit  = f_bits[4'd15 - r_k];
        n5     = r_y[20:16];
        ex_sh  = ({1'b0, r_r} + (32'd1 << (n5 - 5'd1))) >> n5;
        lg_neg = $signed({2'b00, r_sh, 16'd0}) - $signed({7'd0, r_frac});
        lg_pos = lg_neg > 23'sd0;
        m2     = r_prod[61:30];
        sig_small = div_rsp.quotient[30:0];
        sig_d  = {1'b0, ONE_Q30} + {1'b0, r_r};
        sum_nx = {1'b0, r_sum} + {19'd0, r_loss};
        mean_dvd = {1'b0, r_sum} + {29'd0, r_count[20:1]};
        if (r_count == '0) begin
            mean_q = '0;
        end else if (|div_rsp.quotient[63:32]) begin
            mean_q = '1;
        end else begin
            mean_q = div_rsp.quotient[31:0];
        end
        out_free = !r_ov || i_out_ready;
    end

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_Y_MUL;
            ST_Y_MUL:     n_state = ST_Y_GET;
            ST_Y_GET:     n_state = ST_EX_INIT;
            ST_EX_INIT:   n_state = (r_y[24:16] > 9'd30) ? r_ret : ST_EX_LOOP;
            ST_EX_LOOP: begin
                if (f_bit) begin
                    n_state = ST_EX_ACC;
                end else if (r_k == 4'd15) begin
                    n_state = ST_EX_SHIFT;
                end
            end
            ST_EX_ACC:    n_state = (r_k == 4'd15) ? ST_EX_SHIFT : ST_EX_LOOP;
            ST_EX_SHIFT:  n_state = r_ret;
            ST_SIG_DIV:   n_state = ST_SIG_WAIT;
            ST_SIG_WAIT:  if (div_rsp.done) n_state = ST_LN_SETUP;
            ST_LN_SETUP:  n_state = ST_LG_NORM;
            ST_LG_NORM:   if (r_m[30]) n_state = ST_LG_SQ;
            ST_LG_SQ:     n_state = ST_LG_SQA;
            ST_LG_SQA:    if (r_k == 4'd15) n_state = r_ret; else n_state = ST_LG_SQ;
            ST_LN_MUL: begin
                if (lg_pos) begin
                    n_state = ST_LN_GET;
                end else begin
                    n_state = r_sel ? ST_BCE_M1 : ST_LN_SETUP;
                end
            end
            ST_LN_GET:    n_state = r_sel ? ST_BCE_M1 : ST_LN_SETUP;
            ST_BCE_M1:    n_state = ST_BCE_M2;
            ST_BCE_M2:    n_state = ST_BCE_GET;
            ST_BCE_GET:   n_state = ST_AT_M1;
            ST_AT_M1:     n_state = ST_AT_M2;
            ST_AT_M2:     n_state = ST_AT_GET;
            ST_AT_GET:    n_state = ST_PW_SEL;
            ST_PW_SEL: begin
                if (r_gamma == '0 || r_q == '0) begin
                    n_state = ST_AB_MUL;
                end else begin
                    n_state = ST_LG_NORM;
                end
            end
            ST_PW_MUL:    n_state = ST_PW_GET;
            ST_PW_GET:    n_state = ST_EX_INIT;
            ST_AB_MUL:    n_state = ST_AB_GET;
            ST_AB_GET:    n_state = ST_LOSS_MUL;
            ST_LOSS_MUL:  n_state = ST_LOSS_GET;
            ST_LOSS_GET:  n_state = (r_t > HALF_Q16) ? ST_PW8_MUL : ST_ACCUM;
            ST_PW8_MUL:   n_state = ST_PW8_GET;
            ST_PW8_GET:   n_state = ST_ACCUM;
            ST_ACCUM:     n_state = r_last ? ST_MEAN_DIV : ST_IDLE;
            ST_MEAN_DIV:  n_state = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (div_rsp.done) n_state = ST_OUT;
            ST_OUT:       if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = {3'd0, r_r, 30'd0} + {33'd0, sig_d[31:1]};
        div_req.divisor  = sig_d;
        o_in_ready       = 1'b0;
        case (r_state)
            ST_IDLE:     o_in_ready = 1'b1;
            ST_Y_MUL: begin
                mul_a = {10'd0, r_mag};
                mul_b = {1'b0, LOG2E_Q30};
            end
            ST_EX_LOOP: begin
                mul_a = {1'b0, r_r};
                mul_b = {2'd0, POW_TAB[r_k]};
            end
            ST_LG_SQ: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            ST_LN_MUL: begin
                mul_a = {11'd0, lg_neg[20:0]};
                mul_b = {2'd0, LN2_Q30};
            end
            ST_BCE_M1: begin
                mul_a = {15'd0, r_t};
                mul_b = {10'd0, r_aln};
            end
            ST_BCE_M2: begin
                mul_a = {15'd0, ONE_Q16 - r_t};
                mul_b = {10'd0, r_bln};
            end
            ST_AT_M1: begin
                mul_a = {15'd0, r_t};
                mul_b = {15'd0, r_alpha};
            end
            ST_AT_M2: begin
                mul_a = {15'd0, ONE_Q16 - r_t};
                mul_b = {15'd0, ONE_Q16 - r_alpha};
            end
            ST_PW_MUL: begin
                mul_a = {11'd0, lg_neg[20:0]};
                mul_b = {16'd0, r_gamma};
            end
            ST_AB_MUL: begin
                mul_a = {15'd0, r_at};
                mul_b = {10'd0, r_bce};
            end
            ST_LOSS_MUL: begin
                mul_a = {10'd0, r_ab};
                mul_b = {1'b0, r_r};
            end
            ST_PW8_MUL: begin
                mul_a = {2'd0, r_loss};
                mul_b = {16'd0, r_pos_w};
            end
            ST_SIG_DIV:  div_req.start = 1'b1;
            ST_MEAN_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {15'd0, mean_dvd};
                div_req.divisor  = {11'd0, r_count};
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------ control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_pos_w  <= POS_WEIGHT_RST;
            r_gamma  <= FOCUS_GAMMA_RST;
            r_balpha <= BALANCE_ALPHA_RST;
            r_sum    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_POS_WEIGHT:    r_pos_w  <= i_cfg_wdata[15:0];
                    REG_FOCUS_GAMMA:   r_gamma  <= i_cfg_wdata[15:0];
                    REG_BALANCE_ALPHA: r_balpha <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                ST_Y_GET:    r_ret <= ST_SIG_DIV;
                ST_LN_SETUP: r_ret <= ST_LN_MUL;
                ST_PW_SEL:   r_ret <= ST_PW_MUL;
                ST_PW_GET:   r_ret <= ST_AB_MUL;
                default: ;
            endcase
            if (r_state == ST_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == ST_ACCUM) begin
                if (r_count >= LIMIT_W) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    if (sum_nx[48]) begin
                        r_sum <= '1;
                        r_ovf <= 1'b1;
                    end else begin
                        r_sum <= sum_nx[47:0];
                    end
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_sum   <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_mean <= mean_q;
            r_bcnt <= r_count;
            r_sat  <= r_ovf;
        end
    end

    // ------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_mag   <= l_abs[21:0];
                    r_neg_l <= l_cl[23];
                    r_t     <= (i_label > ONE_Q16) ? ONE_Q16 : i_label;
                    r_alpha <= (r_balpha > ONE_Q16) ? ONE_Q16 : r_balpha;
                    r_last  <= i_last;
                    r_sel   <= 1'b0;
                end
            end
            ST_Y_GET:    r_y <= 25'((r_prod + (64'd1 << 29)) >> 30);
            ST_EX_INIT: begin
                r_k <= '0;
                r_r <= (r_y[24:16] > 9'd30) ? 31'd0 : ONE_Q30;
            end
            ST_EX_LOOP:  if (!f_bit && r_k != 4'd15) r_k <= r_k + 1'b1;
            ST_EX_ACC: begin
                r_r <= 31'((r_prod + (64'd1 << 29)) >> 30);
                r_k <= r_k + 1'b1;
            end
            ST_EX_SHIFT: if (n5 != '0) r_r <= ex_sh[30:0];
            ST_SIG_WAIT: begin
                if (div_rsp.done) begin
                    if (r_neg_l) begin
                        r_p <= sig_small;
                        r_q <= ONE_Q30 - sig_small;
                    end else begin
                        r_p <= ONE_Q30 - sig_small;
                        r_q <= sig_small;
                    end
                end
            end
            ST_LN_SETUP: begin
                r_m    <= (r_sel ? r_q : r_p) + EPS_Q30;
                r_sh   <= '0;
                r_frac <= '0;
                r_k    <= '0;
            end
            ST_LG_NORM: begin
                if (!r_m[30]) begin
                    r_m  <= {r_m[29:0], 1'b0};
                    r_sh <= r_sh + 1'b1;
                end
            end
            ST_LG_SQA: begin
                // truncated square, renormalise into [1,2)
                if (m2[31]) begin
                    r_m <= m2[31:1];
                    r_frac[4'd15 - r_k] <= 1'b1;
                end else begin
                    r_m <= m2[30:0];
                end
                r_k <= r_k + 1'b1;
            end
            ST_LN_MUL: begin
                if (!lg_pos) begin
                    if (r_sel) r_bln <= '0; else r_aln <= '0;
                    r_sel <= 1'b1;
                end
            end
            ST_LN_GET: begin
                if (r_sel) begin
                    r_bln <= 22'((r_prod + (64'd1 << 29)) >> 30);
                end else begin
                    r_aln <= 22'((r_prod + (64'd1 << 29)) >> 30);
                end
                r_sel <= 1'b1;
            end
            ST_BCE_M2:   r_acc <= r_prod[37:0];
            ST_BCE_GET:  r_bce <= 22'(({26'd0, r_acc} + r_prod + 64'd32768) >> 16);
            ST_AT_M2:    r_acc <= r_prod[37:0];
            ST_AT_GET:   r_at  <= 17'(({26'd0, r_acc} + r_prod + 64'd32768) >> 16);
            ST_PW_SEL: begin
                if (r_gamma == '0) begin
                    r_r <= ONE_Q30;
                end else if (r_q == '0) begin
                    r_r <= '0;
                end
                r_m    <= r_q;
                r_sh   <= '0;
                r_frac <= '0;
                r_k    <= '0;
            end
            ST_PW_GET:   r_y    <= 25'((r_prod + 64'd2048) >> 12);
            ST_AB_GET:   r_ab   <= 22'((r_prod + 64'd32768) >> 16);
            ST_LOSS_GET: r_loss <= 30'((r_prod + (64'd1 << 29)) >> 30);
            ST_PW8_GET:  r_loss <= 30'((r_prod + 64'd128) >> 8);
            default: ;
        endcase
    end

    assign o_out_valid   = r_ov;
    assign o_mean_loss   = r_mean;
    assign o_batch_count = r_bcnt;
    assign o_saturated   = r_sat;

    // ------------------------------------------------------------ assertions
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPLY(a_count_limit, i_clk, i_rst_n, 1'b1, r_count <= LIMIT_W)
    `ASSERT_IMPLY(a_out_count, i_clk, i_rst_n, o_out_valid, o_batch_count != '0)
    `ASSERT_NEXT(a_out_clears, i_clk, i_rst_n, r_state == ST_OUT && out_free, o_out_valid && r_count == '0)

endmodule

`default_nettype wire

// ===== rtl/fbce_div.sv =====
// ----------------------------------------------------------------------------
// fbce_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbce_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fbce_pkg::t_div_req i_req,
    output fbce_pkg::t_div_rsp     o_rsp
);
    import fbce_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W + 1);

    logic [DIV_DVD_W-1:0] r_quo;
    logic [DIV_DVS_W-1:0] r_rem;
    logic [DIV_DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DVS_W:0] sh;
    logic [DIV_DVS_W:0] diff;
    logic               ge;

    always_comb begin
        sh   = {r_rem, r_quo[DIV_DVD_W-1]};
        diff = sh - {1'b0, r_dvs};
        ge   = sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DVS_W-1:0] : sh[DIV_DVS_W-1:0];
            r_quo <= {r_quo[DIV_DVD_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire
